// ===== rtl/dbcd_pkg.sv =====
// ---------------------------------------------------------------------------
// dbcd_pkg
// Shared widths for the cycle-detection duplicate finder.
// ---------------------------------------------------------------------------
package dbcd_pkg;

  // Store depth and derived widths
  localparam int MAX_ENTRIES = 1024;
  localparam int VAL_W       = 10;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int GRD_W       = CNT_W + 2;
  localparam int CMP_W       = (VAL_W > CNT_W) ? VAL_W : CNT_W;

endpackage

// ===== rtl/dbcd_if.sv =====
// ---------------------------------------------------------------------------
// dbcd_in_if / dbcd_out_if
// Valid/ready channels for array elements and search results.
// ---------------------------------------------------------------------------
interface dbcd_in_if
  import dbcd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] element;
  logic             last;

  modport source (output valid, output element, output last, input ready);
  modport sink   (input valid, input element, input last, output ready);
endinterface

interface dbcd_out_if
  import dbcd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] duplicate;
  logic             error;

  modport source (output valid, output duplicate, output error, input ready);
  modport sink   (input valid, input duplicate, input error, output ready);
endinterface

// ===== rtl/dbcd_ram.sv =====
// ---------------------------------------------------------------------------
// dbcd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/duplicate_by_cycle_detection.sv =====
// ---------------------------------------------------------------------------
// duplicate_by_cycle_detection
// Finds the repeated value of an array by tortoise-and-hare pointer walking.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one array element per transfer, stored at index 0 upward.
//   A transfer with last = 1 closes the array and starts the search; no
//   element is taken until that search is finished.
//   out_ch carries one result per closed array: duplicate, or error = 1 with
//   duplicate = 0 when a value lies outside 1..count-1, when fewer than two
//   elements were given, or when more than MAX_ENTRIES elements arrived.
// Operation:
//   Elements that do not close the array are taken while the sequencer idles.
//   The search shares the single read port of the value store: each
//   meeting-phase step makes three dependent reads and a compare, each
//   entry-phase step two reads and a compare; range errors skip the walk.
// Reset: synchronous rst_n clears sequencer, element count and output valid;
//   the store needs no clearing, only freshly loaded entries are read.
// Stall: a pending result sits in the output register; new elements load
//   meanwhile, and a finished search waits until the register is free.
// ---------------------------------------------------------------------------
module duplicate_by_cycle_detection
  import dbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dbcd_in_if.sink     in_ch,
  dbcd_out_if.source  out_ch
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_P1_RS  = 4'd1;
  localparam logic [3:0] ST_P1_RF1 = 4'd2;
  localparam logic [3:0] ST_P1_RF2 = 4'd3;
  localparam logic [3:0] ST_P1_CMP = 4'd4;
  localparam logic [3:0] ST_P2_RS  = 4'd5;
  localparam logic [3:0] ST_P2_RE  = 4'd6;
  localparam logic [3:0] ST_P2_CMP = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bad_r, bad_nxt;
  logic             zero_r, zero_nxt;
  logic [VAL_W-1:0] max_r, max_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [VAL_W-1:0] slow_r, slow_nxt;
  logic [VAL_W-1:0] fast_r, fast_nxt;
  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic [GRD_W-1:0] guard_r, guard_nxt;
  logic [GRD_W-1:0] limit_r, limit_nxt;
  logic [VAL_W-1:0] res_dup_r, res_dup_nxt;
  logic             res_err_r, res_err_nxt;
  logic [VAL_W-1:0] out_dup_r, out_dup_nxt;
  logic             out_err_r, out_err_nxt;

  logic              acc;
  logic              room;
  logic              we;
  logic [ADDR_W-1:0] raddr;
  logic [VAL_W-1:0]  rdata;
  logic [CNT_W-1:0]  n_fin;
  logic              zero_all;
  logic [VAL_W-1:0]  max_all;
  logic              range_err;
  logic [GRD_W-1:0]  guard_inc;
  logic              out_free;

  // value store
  dbcd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_ch.element),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.duplicate = out_dup_r;
  assign out_ch.error     = out_err_r;

  assign acc       = in_ch.valid && in_ch.ready;
  assign room      = (cnt_r < CNT_W'(MAX_ENTRIES));
  assign we        = acc && room;
  assign guard_inc = guard_r + GRD_W'(1);
  assign out_free  = !out_valid_r || out_ch.ready;

  // range bookkeeping including the closing element
  always_comb begin
    n_fin    = room ? (cnt_r + CNT_W'(1)) : cnt_r;
    zero_all = zero_r || (room && (in_ch.element == '0));
    max_all  = (room && (in_ch.element > max_r)) ? in_ch.element : max_r;
    range_err = bad_r || !room || zero_all || (n_fin < CNT_W'(2)) ||
                (CMP_W'(max_all) >= CMP_W'(n_fin));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    zero_nxt      = zero_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    entry_nxt     = entry_r;
    guard_nxt     = guard_r;
    limit_nxt     = limit_r;
    res_dup_nxt   = res_dup_r;
    res_err_nxt   = res_err_r;
    out_dup_nxt   = out_dup_r;
    out_err_nxt   = out_err_r;
    raddr         = ADDR_W'(slow_r);

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (room) begin
            cnt_nxt  = cnt_r + CNT_W'(1);
            zero_nxt = zero_all;
            max_nxt  = max_all;
          end else begin
            bad_nxt = 1'b1;
          end
          if (in_ch.last) begin
            cnt_nxt   = '0;
            bad_nxt   = 1'b0;
            zero_nxt  = 1'b0;
            max_nxt   = '0;
            limit_nxt = GRD_W'({n_fin, 1'b0}) + GRD_W'(2);
            slow_nxt  = '0;
            fast_nxt  = '0;
            guard_nxt = '0;
            if (range_err) begin
              res_err_nxt = 1'b1;
              res_dup_nxt = '0;
              state_nxt   = ST_DONE;
            end else begin
              state_nxt = ST_P1_RS;
            end
          end
        end
      end
      // meeting phase: slow one step, fast two steps
      ST_P1_RS: begin
        raddr     = ADDR_W'(slow_r);
        state_nxt = ST_P1_RF1;
      end
      ST_P1_RF1: begin
        slow_nxt  = rdata;
        raddr     = ADDR_W'(fast_r);
        state_nxt = ST_P1_RF2;
      end
      ST_P1_RF2: begin
        raddr     = ADDR_W'(rdata);
        state_nxt = ST_P1_CMP;
      end
      ST_P1_CMP: begin
        fast_nxt = rdata;
        if (slow_r == rdata) begin
          entry_nxt = '0;
          guard_nxt = '0;
          state_nxt = ST_P2_RS;
        end else if (guard_inc >= limit_r) begin
          res_err_nxt = 1'b1;
          res_dup_nxt = '0;
          state_nxt   = ST_DONE;
        end else begin
          guard_nxt = guard_inc;
          state_nxt = ST_P1_RS;
        end
      end
      // entry phase: slow and entry one step each
      ST_P2_RS: begin
        raddr     = ADDR_W'(slow_r);
        state_nxt = ST_P2_RE;
      end
      ST_P2_RE: begin
        slow_nxt  = rdata;
        raddr     = ADDR_W'(entry_r);
        state_nxt = ST_P2_CMP;
      end
      ST_P2_CMP: begin
        entry_nxt = rdata;
        if (slow_r == rdata) begin
          res_err_nxt = 1'b0;
          res_dup_nxt = slow_r;
          state_nxt   = ST_DONE;
        end else if (guard_inc >= limit_r) begin
          res_err_nxt = 1'b1;
          res_dup_nxt = '0;
          state_nxt   = ST_DONE;
        end else begin
          guard_nxt = guard_inc;
          state_nxt = ST_P2_RS;
        end
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = res_dup_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      zero_r      <= 1'b0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
      zero_r      <= zero_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    slow_r    <= slow_nxt;
    fast_r    <= fast_nxt;
    entry_r   <= entry_nxt;
    guard_r   <= guard_nxt;
    limit_r   <= limit_nxt;
    res_dup_r <= res_dup_nxt;
    res_err_r <= res_err_nxt;
    out_dup_r <= out_dup_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule
